// File: rtl/core/gas_pkg.sv
// gas_pkg: constants shared by the grid path search core and its channel interfaces
// no dependencies; compile before every other file of the block

package gas_pkg;

    // opcodes of the command channel
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // fixed field widths
    localparam int OPC_W   = 2;
    localparam int CRD_W   = 5;
    localparam int STEP_W  = 10;
    localparam int LEN_W   = 10;
    localparam int G_W     = 16;
    localparam int H_W     = 10;

    // distance arithmetic
    localparam int DCRD_W    = 6;     // coordinate difference, grids up to 64 cells a side
    localparam int SQ_W      = 20;    // 100 * (dx^2 + dy^2) fits here
    localparam int SQ_ITER   = SQ_W / 2;
    localparam int SQ_IT_W   = 4;
    localparam int SCALE_SQ  = 100;
    localparam int STEP_ORTH = 10;
    localparam int STEP_DIAG = 14;
    localparam int LEN_MAX   = 1023;
    localparam logic [G_W-1:0] G_MAX = '1;

    // neighbor offset counter codes (offset = code - 1)
    localparam logic [1:0] NB_FIRST = 2'd0;
    localparam logic [1:0] NB_MID   = 2'd1;
    localparam logic [1:0] NB_LAST  = 2'd2;

endpackage

// File: rtl/core/gas_cmd_if.sv
// gas_cmd_if: command channel (load, search, read) with valid/ready handshake
// depends on gas_pkg

interface gas_cmd_if import gas_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [CRD_W-1:0]  cell_x;
    logic [CRD_W-1:0]  cell_y;
    logic              walkable;
    logic [CRD_W-1:0]  start_x;
    logic [CRD_W-1:0]  start_y;
    logic [CRD_W-1:0]  goal_x;
    logic [CRD_W-1:0]  goal_y;
    logic [STEP_W-1:0] step_index;

    modport source (
        output valid, opcode, cell_x, cell_y, walkable, start_x, start_y,
               goal_x, goal_y, step_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, cell_x, cell_y, walkable, start_x, start_y,
               goal_x, goal_y, step_index,
        output ready
    );
endinterface

// File: rtl/core/gas_rsp_if.sv
// gas_rsp_if: result channel with valid/ready handshake
// depends on gas_pkg

interface gas_rsp_if import gas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [LEN_W-1:0] path_length;
    logic [G_W-1:0]   distance;
    logic [CRD_W-1:0] step_x;
    logic [CRD_W-1:0] step_y;

    modport source (
        output valid, found, path_length, distance, step_x, step_y,
        input  ready
    );
    modport sink (
        input  valid, found, path_length, distance, step_x, step_y,
        output ready
    );
endinterface

// File: rtl/core/grid_astar_path_search.sv
// grid_astar_path_search: eight-connected grid path search with node, map and path memories
// depends on gas_pkg, gas_cmd_if, gas_rsp_if
//
// channel | dir | transfer carries
// --------+-----+---------------------------------------------------------------
// cmd     | in  | opcode, cell_x/y, walkable, start_x/y, goal_x/y, step_index
// rsp     | out | found, path_length, distance, step_x, step_y (one per command)
//
// sequence: a search runs one clearing pass over the node memory, a start setup that
//   computes the heuristic of the start cell, then per expanded cell a full scan of the node
//   memory plus a visit to each of the 8 neighbors (an updated neighbor runs the iterative
//   square root for its heuristic), and at the end the retrace walks the path twice
// reset: a clearing pass over all cells empties the map memory; cmd.ready stays low meanwhile
// stalls: one command at a time; cmd.ready is high only while idle, and a finished result
//   waits in the output register until rsp.ready takes it

module grid_astar_path_search import gas_pkg::*; #(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    gas_cmd_if.sink   cmd,
    gas_rsp_if.source rsp
);

    localparam int GRID_N = GRID_WIDTH * GRID_HEIGHT;
    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int IW     = $clog2(GRID_N);
    localparam int CNTW   = $clog2(GRID_N + 1);

    // per-cell search record
    typedef struct packed {
        logic          open;
        logic          closed;
        logic          hp;
        logic [G_W-1:0] g;
        logic [H_W-1:0] h;
        logic [YW-1:0] cfy;
        logic [XW-1:0] cfx;
    } node_t;

    typedef struct packed {
        logic [YW-1:0] y;
        logic [XW-1:0] x;
    } crd_t;

    // sequencer states
    localparam logic [4:0] S_RCLR     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_RD       = 5'd2;
    localparam logic [4:0] S_FIN      = 5'd3;
    localparam logic [4:0] S_SCLR     = 5'd4;
    localparam logic [4:0] S_SQ_PREP  = 5'd5;
    localparam logic [4:0] S_SQ_RUN   = 5'd6;
    localparam logic [4:0] S_START_WR = 5'd7;
    localparam logic [4:0] S_SCAN     = 5'd8;
    localparam logic [4:0] S_SCAN_TL  = 5'd9;
    localparam logic [4:0] S_SCAN_DEC = 5'd10;
    localparam logic [4:0] S_NB_ISS   = 5'd11;
    localparam logic [4:0] S_NB_DAT   = 5'd12;
    localparam logic [4:0] S_NB_WR    = 5'd13;
    localparam logic [4:0] S_NB_NEXT  = 5'd14;
    localparam logic [4:0] S_RT1_CHK  = 5'd15;
    localparam logic [4:0] S_RT1_DAT  = 5'd16;
    localparam logic [4:0] S_RT2_CHK  = 5'd17;
    localparam logic [4:0] S_RT2_DAT  = 5'd18;

    function automatic logic [IW-1:0] cell_idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return IW'(y) * IW'(GRID_WIDTH) + IW'(x);
    endfunction

    function automatic logic [DCRD_W-1:0] adiff(input logic [DCRD_W-1:0] a,
                                                input logic [DCRD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // memories
    node_t node_mem [GRID_N];
    logic  walk_mem [GRID_N];
    crd_t  path_mem [GRID_N];

    node_t node_rd_reg;
    logic  walk_rd_reg;
    crd_t  path_rd_reg;

    // control and datapath registers
    logic [4:0]      state_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] pos_reg;
    logic [XW-1:0]   sc_x_reg, px_reg, best_x_reg, s_x_reg, g_x_reg, rt_x_reg, rd_x_reg;
    logic [YW-1:0]   sc_y_reg, py_reg, best_y_reg, s_y_reg, g_y_reg, rt_y_reg, rd_y_reg;
    logic            pv_reg, have_reg, range_ok_reg, sq_ret_reg;
    logic [G_W:0]    bf_reg;
    logic [H_W-1:0]  bh_reg;
    node_t           best_q_reg;
    logic [1:0]      ndx_reg, ndy_reg;
    logic [DCRD_W-1:0] dx_reg, dy_reg;
    logic [G_W-1:0]  ng_reg;
    logic [SQ_W-1:0] sq_rem_reg, sq_root_reg, sq_bit_reg;
    logic [SQ_IT_W-1:0] sq_it_reg;
    logic            goal_reached_reg;
    logic [G_W-1:0]  goal_dist_reg;
    logic [CNTW-1:0] path_count_reg;
    logic            out_valid_reg, out_found_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic [G_W-1:0]  out_dist_reg;
    logic [CRD_W-1:0] out_x_reg, out_y_reg;

    // memory port controls
    logic            node_we, walk_we, walk_wdata, path_we;
    logic [IW-1:0]   node_waddr, node_raddr, walk_waddr, walk_raddr, path_waddr, path_raddr;
    node_t           node_wdata;
    crd_t            path_wdata;

    // neighbor of the expanded cell
    logic [XW:0]     nx_w;
    logic [YW:0]     ny_w;
    logic [XW-1:0]   n_x;
    logic [YW-1:0]   n_y;
    logic            nb_ok, nb_mid, nb_diag;
    logic [IW-1:0]   n_idx;
    logic [G_W:0]    ng_sum;
    logic [G_W-1:0]  ng;
    logic            nb_upd;

    // scan compare
    logic [G_W:0]    scan_f;
    logic            scan_take;

    // square root step
    logic [SQ_W-1:0] sq_trial;
    logic [2*DCRD_W:0] sq_sum;

    logic            cmd_xfer, rsp_xfer, last_cell, at_goal;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign rsp_xfer  = rsp.valid && rsp.ready;
    assign last_cell = (cnt_reg == CNTW'(GRID_N - 1));

    assign nx_w    = {1'b0, best_x_reg} + (XW+1)'(ndx_reg);
    assign ny_w    = {1'b0, best_y_reg} + (YW+1)'(ndy_reg);
    assign nb_mid  = (ndx_reg == NB_MID) && (ndy_reg == NB_MID);
    assign nb_ok   = (nx_w != '0) && (32'(nx_w) <= GRID_WIDTH)
                  && (ny_w != '0) && (32'(ny_w) <= GRID_HEIGHT) && !nb_mid;
    assign n_x     = XW'(nx_w - (XW+1)'(1));
    assign n_y     = YW'(ny_w - (YW+1)'(1));
    assign n_idx   = cell_idx(n_x, n_y);
    assign nb_diag = (ndx_reg != NB_MID) && (ndy_reg != NB_MID);
    assign ng_sum  = {1'b0, best_q_reg.g}
                   + (G_W+1)'(nb_diag ? STEP_DIAG : STEP_ORTH);
    assign ng      = ng_sum[G_W] ? G_MAX : ng_sum[G_W-1:0];
    assign nb_upd  = !node_rd_reg.hp || (node_rd_reg.g > ng);
    assign at_goal = (best_x_reg == g_x_reg) && (best_y_reg == g_y_reg);

    assign scan_f    = {1'b0, node_rd_reg.g} + (G_W+1)'(node_rd_reg.h);
    assign scan_take = pv_reg && node_rd_reg.open
                    && (!have_reg || (scan_f < bf_reg)
                        || ((scan_f == bf_reg) && (node_rd_reg.h < bh_reg)));

    assign sq_trial = sq_root_reg + sq_bit_reg;
    assign sq_sum   = (2*DCRD_W+1)'(dx_reg * dx_reg) + (2*DCRD_W+1)'(dy_reg * dy_reg);

    // memory port steering
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_raddr = '0;
        walk_we    = 1'b0;
        walk_waddr = '0;
        walk_wdata = 1'b0;
        walk_raddr = '0;
        path_we    = 1'b0;
        path_waddr = '0;
        path_wdata = '0;
        path_raddr = '0;
        unique case (state_reg)
            S_RCLR:
            begin
                walk_we    = 1'b1;
                walk_waddr = cnt_reg[IW-1:0];
            end
            S_IDLE:
            begin
                if (cmd_xfer && cmd.opcode == OP_LOAD
                    && 32'(cmd.cell_x) < GRID_WIDTH && 32'(cmd.cell_y) < GRID_HEIGHT)
                begin
                    walk_we    = 1'b1;
                    walk_waddr = cell_idx(XW'(cmd.cell_x), YW'(cmd.cell_y));
                    walk_wdata = cmd.walkable;
                end
                path_raddr = IW'(cmd.step_index);
            end
            S_SCLR:
            begin
                node_we    = 1'b1;
                node_waddr = cnt_reg[IW-1:0];
            end
            S_START_WR:
            begin
                // start cell opens with zero cost and no parent
                node_we         = 1'b1;
                node_waddr      = cell_idx(s_x_reg, s_y_reg);
                node_wdata.open = 1'b1;
                node_wdata.h    = sq_root_reg[H_W-1:0];
            end
            S_SCAN:
                node_raddr = cnt_reg[IW-1:0];
            S_SCAN_DEC:
            begin
                // move the chosen cell from open to closed
                node_we           = have_reg;
                node_waddr        = cell_idx(best_x_reg, best_y_reg);
                node_wdata        = best_q_reg;
                node_wdata.open   = 1'b0;
                node_wdata.closed = 1'b1;
            end
            S_NB_ISS:
            begin
                node_raddr = n_idx;
                walk_raddr = n_idx;
            end
            S_NB_DAT:
            begin
                // already has a parent at no higher cost: only mark it open
                node_we         = walk_rd_reg && !node_rd_reg.closed && !nb_upd;
                node_waddr      = n_idx;
                node_wdata      = node_rd_reg;
                node_wdata.open = 1'b1;
            end
            S_NB_WR:
            begin
                node_we    = 1'b1;
                node_waddr = n_idx;
                node_wdata = '{open: 1'b1, closed: 1'b0, hp: 1'b1, g: ng_reg,
                               h: sq_root_reg[H_W-1:0], cfy: best_y_reg, cfx: best_x_reg};
            end
            S_RT1_CHK:
                node_raddr = cell_idx(rt_x_reg, rt_y_reg);
            S_RT2_CHK:
            begin
                path_we    = (pos_reg != '0);
                path_waddr = IW'(pos_reg - CNTW'(1));
                path_wdata = '{y: rt_y_reg, x: rt_x_reg};
                node_raddr = cell_idx(rt_x_reg, rt_y_reg);
            end
            default:
            begin
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (walk_we)
        begin
            walk_mem[walk_waddr] <= walk_wdata;
        end
        walk_rd_reg <= walk_mem[walk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rd_reg <= path_mem[path_raddr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_RCLR;
            cnt_reg          <= '0;
            pos_reg          <= '0;
            sc_x_reg         <= '0;
            sc_y_reg         <= '0;
            px_reg           <= '0;
            py_reg           <= '0;
            pv_reg           <= 1'b0;
            have_reg         <= 1'b0;
            bf_reg           <= '0;
            bh_reg           <= '0;
            best_x_reg       <= '0;
            best_y_reg       <= '0;
            best_q_reg       <= '0;
            s_x_reg          <= '0;
            s_y_reg          <= '0;
            g_x_reg          <= '0;
            g_y_reg          <= '0;
            range_ok_reg     <= 1'b0;
            sq_ret_reg       <= 1'b0;
            ndx_reg          <= NB_FIRST;
            ndy_reg          <= NB_FIRST;
            dx_reg           <= '0;
            dy_reg           <= '0;
            ng_reg           <= '0;
            sq_rem_reg       <= '0;
            sq_root_reg      <= '0;
            sq_bit_reg       <= '0;
            sq_it_reg        <= '0;
            rt_x_reg         <= '0;
            rt_y_reg         <= '0;
            rd_x_reg         <= '0;
            rd_y_reg         <= '0;
            goal_reached_reg <= 1'b0;
            goal_dist_reg    <= '0;
            path_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_found_reg    <= 1'b0;
            out_len_reg      <= '0;
            out_dist_reg     <= '0;
            out_x_reg        <= '0;
            out_y_reg        <= '0;
        end
        else
        begin
            pv_reg <= (state_reg == S_SCAN);
            // in the finish step the output register is reloaded below instead
            if (rsp_xfer && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            if (scan_take)
            begin
                have_reg   <= 1'b1;
                bf_reg     <= scan_f;
                bh_reg     <= node_rd_reg.h;
                best_x_reg <= px_reg;
                best_y_reg <= py_reg;
                best_q_reg <= node_rd_reg;
            end

            unique case (state_reg)
                S_RCLR:
                begin
                    cnt_reg <= cnt_reg + CNTW'(1);
                    if (last_cell)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_xfer)
                    begin
                        rd_x_reg <= '0;
                        rd_y_reg <= '0;
                        cnt_reg  <= '0;
                        priority if (cmd.opcode == OP_SEARCH)
                        begin
                            s_x_reg          <= XW'(cmd.start_x);
                            s_y_reg          <= YW'(cmd.start_y);
                            g_x_reg          <= XW'(cmd.goal_x);
                            g_y_reg          <= YW'(cmd.goal_y);
                            range_ok_reg     <= 32'(cmd.start_x) < GRID_WIDTH
                                             && 32'(cmd.start_y) < GRID_HEIGHT
                                             && 32'(cmd.goal_x) < GRID_WIDTH
                                             && 32'(cmd.goal_y) < GRID_HEIGHT;
                            goal_reached_reg <= 1'b0;
                            goal_dist_reg    <= '0;
                            path_count_reg   <= '0;
                            state_reg        <= S_SCLR;
                        end
                        else if (cmd.opcode == OP_READ
                                 && 32'(cmd.step_index) < 32'(path_count_reg))
                        begin
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_RD:
                begin
                    rd_x_reg  <= path_rd_reg.x;
                    rd_y_reg  <= path_rd_reg.y;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= goal_reached_reg;
                        out_len_reg   <= (32'(path_count_reg) > LEN_MAX)
                                       ? LEN_W'(LEN_MAX) : LEN_W'(path_count_reg);
                        out_dist_reg  <= goal_dist_reg;
                        out_x_reg     <= CRD_W'(rd_x_reg);
                        out_y_reg     <= CRD_W'(rd_y_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                S_SCLR:
                begin
                    cnt_reg <= cnt_reg + CNTW'(1);
                    if (last_cell)
                    begin
                        if (range_ok_reg)
                        begin
                            // heuristic of the start cell first
                            dx_reg     <= adiff(DCRD_W'(s_x_reg), DCRD_W'(g_x_reg));
                            dy_reg     <= adiff(DCRD_W'(s_y_reg), DCRD_W'(g_y_reg));
                            sq_ret_reg <= 1'b0;
                            state_reg  <= S_SQ_PREP;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_SQ_PREP:
                begin
                    sq_rem_reg  <= SQ_W'(sq_sum) * SQ_W'(SCALE_SQ);
                    sq_root_reg <= '0;
                    sq_bit_reg  <= SQ_W'(1) << (SQ_W - 2);
                    sq_it_reg   <= '0;
                    state_reg   <= S_SQ_RUN;
                end
                S_SQ_RUN:
                begin
                    // one result bit per cycle
                    if (sq_rem_reg >= sq_trial)
                    begin
                        sq_rem_reg  <= sq_rem_reg - sq_trial;
                        sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_root_reg <= sq_root_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_it_reg  <= sq_it_reg + SQ_IT_W'(1);
                    if (sq_it_reg == SQ_IT_W'(SQ_ITER - 1))
                    begin
                        state_reg <= sq_ret_reg ? S_NB_WR : S_START_WR;
                    end
                end
                S_START_WR:
                begin
                    cnt_reg   <= '0;
                    sc_x_reg  <= '0;
                    sc_y_reg  <= '0;
                    have_reg  <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // sweep all cells, compare one record per cycle
                    px_reg  <= sc_x_reg;
                    py_reg  <= sc_y_reg;
                    cnt_reg <= cnt_reg + CNTW'(1);
                    if (sc_x_reg == XW'(GRID_WIDTH - 1))
                    begin
                        sc_x_reg <= '0;
                        sc_y_reg <= sc_y_reg + YW'(1);
                    end
                    else
                    begin
                        sc_x_reg <= sc_x_reg + XW'(1);
                    end
                    if (last_cell)
                    begin
                        state_reg <= S_SCAN_TL;
                    end
                end
                S_SCAN_TL:
                    state_reg <= S_SCAN_DEC;
                S_SCAN_DEC:
                begin
                    ndx_reg   <= NB_FIRST;
                    ndy_reg   <= NB_FIRST;
                    state_reg <= have_reg ? S_NB_ISS : S_FIN;
                end
                S_NB_ISS:
                    state_reg <= nb_ok ? S_NB_DAT : S_NB_NEXT;
                S_NB_DAT:
                begin
                    if (walk_rd_reg && !node_rd_reg.closed && nb_upd)
                    begin
                        ng_reg     <= ng;
                        dx_reg     <= adiff(DCRD_W'(n_x), DCRD_W'(g_x_reg));
                        dy_reg     <= adiff(DCRD_W'(n_y), DCRD_W'(g_y_reg));
                        sq_ret_reg <= 1'b1;
                        state_reg  <= S_SQ_PREP;
                    end
                    else
                    begin
                        state_reg <= S_NB_NEXT;
                    end
                end
                S_NB_WR:
                    state_reg <= S_NB_NEXT;
                S_NB_NEXT:
                begin
                    if (ndy_reg == NB_LAST)
                    begin
                        ndy_reg <= NB_FIRST;
                        ndx_reg <= ndx_reg + 2'd1;
                    end
                    else
                    begin
                        ndy_reg <= ndy_reg + 2'd1;
                    end
                    if (ndy_reg == NB_LAST && ndx_reg == NB_LAST)
                    begin
                        cnt_reg  <= '0;
                        sc_x_reg <= '0;
                        sc_y_reg <= '0;
                        have_reg <= 1'b0;
                        rt_x_reg <= g_x_reg;
                        rt_y_reg <= g_y_reg;
                        state_reg <= at_goal ? S_RT1_CHK : S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_NB_ISS;
                    end
                end
                S_RT1_CHK:
                begin
                    // count steps back to the start
                    if ((rt_x_reg == s_x_reg && rt_y_reg == s_y_reg)
                        || cnt_reg == CNTW'(GRID_N))
                    begin
                        pos_reg   <= cnt_reg;
                        rt_x_reg  <= g_x_reg;
                        rt_y_reg  <= g_y_reg;
                        state_reg <= S_RT2_CHK;
                    end
                    else
                    begin
                        state_reg <= S_RT1_DAT;
                    end
                end
                S_RT1_DAT:
                begin
                    if (!node_rd_reg.hp)
                    begin
                        pos_reg   <= cnt_reg;
                        rt_x_reg  <= g_x_reg;
                        rt_y_reg  <= g_y_reg;
                        state_reg <= S_RT2_CHK;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + CNTW'(1);
                        rt_x_reg  <= node_rd_reg.cfx;
                        rt_y_reg  <= node_rd_reg.cfy;
                        state_reg <= S_RT1_CHK;
                    end
                end
                S_RT2_CHK:
                begin
                    // store steps from the goal backwards
                    if (pos_reg == '0)
                    begin
                        goal_reached_reg <= 1'b1;
                        goal_dist_reg    <= best_q_reg.g;
                        path_count_reg   <= cnt_reg;
                        state_reg        <= S_FIN;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg - CNTW'(1);
                        state_reg <= S_RT2_DAT;
                    end
                end
                S_RT2_DAT:
                begin
                    rt_x_reg  <= node_rd_reg.cfx;
                    rt_y_reg  <= node_rd_reg.cfy;
                    state_reg <= S_RT2_CHK;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.path_length = out_len_reg;
    assign rsp.distance    = out_dist_reg;
    assign rsp.step_x      = out_x_reg;
    assign rsp.step_y      = out_y_reg;

    // the chosen cell was open when it was picked
    a_best_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_DEC && have_reg) |-> best_q_reg.open)
        else $error("expanded cell was not open");

    // a found path with no steps costs nothing
    a_zero_path: assert property (@(posedge clk) disable iff (!rst_n)
        (goal_reached_reg && path_count_reg == '0) |-> (goal_dist_reg == '0))
        else $error("empty path with nonzero distance");

    // a result appears only out of the finish step
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside finish");

endmodule

// File: test/gas_path_checker.sv
// gas_path_checker: watches the command and result channels, predicts every result
// depends on gas_pkg, gas_cmd_if, gas_rsp_if

`timescale 1ns / 1ps

module gas_path_checker import gas_pkg::*; #(
    parameter int GW = 32,
    parameter int GH = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    gas_cmd_if    cmd_mon,
    gas_rsp_if    rsp_mon,
    output int    errors,
    output int    pending
);

    localparam int NCELL = GW * GH;

    typedef struct packed {
        logic              found;
        logic [LEN_W-1:0]  path_length;
        logic [G_W-1:0]    distance;
        logic [CRD_W-1:0]  step_x;
        logic [CRD_W-1:0]  step_y;
    } search_result_t;

    bit               walk [NCELL];
    logic [G_W-1:0]   g_cost [NCELL];
    logic [H_W-1:0]   h_cost [NCELL];
    int               parent [NCELL];
    bit               has_par [NCELL];
    bit               open_set [NCELL];
    bit               closed_set [NCELL];
    int               route [NCELL];
    int               route_len;
    bit               reached;
    logic [G_W-1:0]   goal_g;

    search_result_t   expected_results[$];

    assign pending = expected_results.size();

    function automatic int isqrt(int v);
        int r;
        int b;
        r = 0;
        b = 1 << 30;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // floor(10 * euclidean distance) between two cells
    function automatic int step_cost(int a, int b);
        int dx;
        int dy;
        dx = (a % GW) - (b % GW);
        dy = (a / GW) - (b / GW);
        return isqrt(100 * (dx * dx + dy * dy));
    endfunction

    function automatic void run_search(int sx, int sy, int gx, int gy);
        int s;
        int g;
        int best;
        int bf;
        int bh;
        int f;
        int n;
        int ng;
        int cnt;
        for (int i = 0; i < NCELL; i++)
        begin
            has_par[i] = 0;
            open_set[i] = 0;
            closed_set[i] = 0;
        end
        reached = 0;
        goal_g = '0;
        route_len = 0;
        if (sx >= GW || sy >= GH || gx >= GW || gy >= GH)
            return;
        s = sy * GW + sx;
        g = gy * GW + gx;
        g_cost[s] = '0;
        h_cost[s] = H_W'(step_cost(s, g));
        open_set[s] = 1;
        forever
        begin
            best = -1;
            bf = 0;
            bh = 0;
            for (int i = 0; i < NCELL; i++)
            begin
                if (open_set[i])
                begin
                    f = int'(g_cost[i]) + int'(h_cost[i]);
                    if (best < 0 || f < bf || (f == bf && int'(h_cost[i]) < bh))
                    begin
                        best = i;
                        bf = f;
                        bh = int'(h_cost[i]);
                    end
                end
            end
            if (best < 0)
                return;
            open_set[best] = 0;
            closed_set[best] = 1;
            for (int dx = -1; dx <= 1; dx++)
            begin
                for (int dy = -1; dy <= 1; dy++)
                begin
                    int nx;
                    int ny;
                    nx = best % GW + dx;
                    ny = best / GW + dy;
                    if (nx < 0 || ny < 0 || nx >= GW || ny >= GH)
                        continue;
                    n = ny * GW + nx;
                    if (!walk[n] || closed_set[n])
                        continue;
                    open_set[n] = 1;
                    ng = int'(g_cost[best]) + step_cost(best, n);
                    if (ng > 65535)
                        ng = 65535;
                    if (!has_par[n] || int'(g_cost[n]) > ng)
                    begin
                        has_par[n] = 1;
                        parent[n] = best;
                        h_cost[n] = H_W'(step_cost(n, g));
                        g_cost[n] = G_W'(ng);
                    end
                end
            end
            if (best == g)
            begin
                // walk back from the goal, then fill the route from its back, goal last
                n = g;
                cnt = 0;
                while (n != s && cnt < NCELL && has_par[n])
                begin
                    cnt++;
                    n = parent[n];
                end
                route_len = cnt;
                n = g;
                while (cnt > 0)
                begin
                    cnt--;
                    route[cnt] = n;
                    n = parent[n];
                end
                reached = 1;
                goal_g = g_cost[g];
                return;
            end
        end
    endfunction

    function automatic search_result_t predict_result();
        search_result_t r;
        int k;
        int c;
        r.step_x = '0;
        r.step_y = '0;
        case (cmd_mon.opcode)
            OP_LOAD:
                walk[int'(cmd_mon.cell_y) * GW + int'(cmd_mon.cell_x)] = cmd_mon.walkable;
            OP_SEARCH:
                run_search(int'(cmd_mon.start_x), int'(cmd_mon.start_y),
                           int'(cmd_mon.goal_x), int'(cmd_mon.goal_y));
            OP_READ:
            begin
                k = int'(cmd_mon.step_index);
                if (k < route_len)
                begin
                    c = route[k];
                    r.step_x = CRD_W'(c % GW);
                    r.step_y = CRD_W'(c / GW);
                end
            end
            default: ;
        endcase
        r.found = reached;
        r.path_length = LEN_W'(route_len > LEN_MAX ? LEN_MAX : route_len);
        r.distance = goal_g;
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        route_len = 0;
        reached = 0;
        goal_g = '0;
        for (int i = 0; i < NCELL; i++)
            walk[i] = 0;
    end

    always @(posedge clk)
    begin
        search_result_t w;
        if (rst_n && cmd_mon.valid && cmd_mon.ready)
            expected_results.insert(expected_results.size(), predict_result());
        if (rst_n && rsp_mon.valid && rsp_mon.ready)
        begin
            if (expected_results.size() == 0)
                report("unexpected result", 0, 0);
            else
            begin
                w = expected_results.pop_front();
                if (rsp_mon.found !== w.found)
                    report("found", rsp_mon.found, w.found);
                if (rsp_mon.path_length !== w.path_length)
                    report("path_length", rsp_mon.path_length, w.path_length);
                if (rsp_mon.distance !== w.distance)
                    report("distance", rsp_mon.distance, w.distance);
                if (rsp_mon.step_x !== w.step_x)
                    report("step_x", rsp_mon.step_x, w.step_x);
                if (rsp_mon.step_y !== w.step_y)
                    report("step_y", rsp_mon.step_y, w.step_y);
            end
        end
    end

endmodule

// File: test/tb_grid_astar_path_search.sv
// tb_grid_astar_path_search: stimulus and verdict for the grid path search core
// depends on gas_pkg, gas_cmd_if, gas_rsp_if, gas_path_checker and the core itself

`timescale 1ns / 1ps

module tb_grid_astar_path_search;
    import gas_pkg::*;

    localparam int GW = 32;
    localparam int GH = 32;
    // each expanded cell costs a full node scan, so the number of walkable
    // cells is kept low to bound the search time
    localparam int WALK_CAP = 22;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle;
    int   recv_idle;
    int   hold_left;
    int   sent;
    bit   walk_shadow [GW*GH];
    int   walk_cnt;

    gas_cmd_if cmd ();
    gas_rsp_if rsp ();

    grid_astar_path_search #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    gas_path_checker #(.GW(GW), .GH(GH)) checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_mon (cmd),
        .rsp_mon (rsp),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // generous upper bound on the run time
    initial
    begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random back-pressure, plus long hold-offs on request
    initial
    begin
        rsp.ready = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp.ready <= 0;
                hold_left <= hold_left - 1;
            end
            else
                rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // one command transfer; unused fields carry random values
    task automatic send(logic [1:0] op, int cx, int cy, bit w, int sx, int sy,
                        int gx, int gy, int k);
        int n;
        cmd.valid      <= 1;
        cmd.opcode     <= op;
        cmd.cell_x     <= CRD_W'(cx);
        cmd.cell_y     <= CRD_W'(cy);
        cmd.walkable   <= w;
        cmd.start_x    <= CRD_W'(sx);
        cmd.start_y    <= CRD_W'(sy);
        cmd.goal_x     <= CRD_W'(gx);
        cmd.goal_y     <= CRD_W'(gy);
        cmd.step_index <= STEP_W'(k);
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
        if ($urandom_range(0, 99) < send_idle)
        begin
            cmd.valid <= 0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge clk);
        end
    endtask

    // load with the walkable count capped; the shadow map mirrors what was written
    task automatic load(int x, int y, bit w);
        if (w && !walk_shadow[y*GW+x] && walk_cnt >= WALK_CAP)
            w = 0;
        walk_cnt += int'(w) - int'(walk_shadow[y*GW+x]);
        walk_shadow[y*GW+x] = w;
        send(OP_LOAD, x, y, w, $urandom_range(0, 31), $urandom_range(0, 31),
             $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1023));
    endtask

    task automatic search(int sx, int sy, int gx, int gy);
        send(OP_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1),
             sx, sy, gx, gy, $urandom_range(0, 1023));
    endtask

    task automatic read_step(int k);
        send(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1),
             $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
             $urandom_range(0, 31), k);
    endtask

    task automatic drain();
        cmd.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // free room under the cap by clearing some walkable cell
    task automatic clear_some();
        int c;
        c = $urandom_range(0, GW*GH-1);
        for (int i = 0; i < GW*GH; i++)
        begin
            if (walk_shadow[(c+i) % (GW*GH)])
            begin
                load(((c+i) % (GW*GH)) % GW, ((c+i) % (GW*GH)) / GW, 0);
                return;
            end
        end
    endtask

    // a well-formed round: build a small walkable patch, search inside it, read the path
    task automatic patch_round();
        int ox;
        int oy;
        int nl;
        int nr;
        ox = $urandom_range(0, 27);
        oy = $urandom_range(0, 27);
        while (walk_cnt >= WALK_CAP - 6)
            clear_some();
        nl = $urandom_range(3, 7);
        repeat (nl)
            load(ox + $urandom_range(0, 4), oy + $urandom_range(0, 4),
                 $urandom_range(0, 9) < 8);
        search(ox + $urandom_range(0, 4), oy + $urandom_range(0, 4),
               ox + $urandom_range(0, 4), oy + $urandom_range(0, 4));
        nr = $urandom_range(1, 4);
        repeat (nr)
            read_step($urandom_range(0, 9) < 8 ? $urandom_range(0, 6) : $urandom_range(0, 1023));
    endtask

    // broken or random traffic, including the unused opcode
    task automatic noise_item();
        case ($urandom_range(0, 3))
            0: send(2'd3, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1),
                    $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 1023));
            1: load($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
            2: search($urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 31));
            default: read_step($urandom_range(0, 1023));
        endcase
    endtask

    task automatic random_phase(int n_items);
        int stop_at;
        stop_at = sent + n_items;
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 80)
                patch_round();
            else
                noise_item();
        end
    endtask

    initial
    begin
        rst_n          = 0;
        cmd.valid      = 0;
        cmd.opcode     = OP_LOAD;
        cmd.cell_x     = '0;
        cmd.cell_y     = '0;
        cmd.walkable   = 0;
        cmd.start_x    = '0;
        cmd.start_y    = '0;
        cmd.goal_x     = '0;
        cmd.goal_y     = '0;
        cmd.step_index = '0;
        send_idle      = 11;
        recv_idle      = 82;
        sent           = 0;
        walk_cnt       = 0;
        for (int i = 0; i < GW*GH; i++)
            walk_shadow[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed: reads and searches on an empty map first
        read_step(0);
        search(0, 0, 0, 0);              // start equals goal
        read_step(0);                    // read beyond an empty path
        search(0, 0, 31, 31);            // goal not walkable
        // corner patch at the far end of the grid
        load(31, 31, 1);
        load(30, 30, 1);
        load(29, 31, 1);
        load(31, 29, 1);
        search(28, 28, 31, 31);          // start not walkable, still expanded
        read_step(0);
        read_step(2);
        read_step(1023);
        search(31, 31, 29, 31);          // short path from the corner through the diagonal cell 30,30
        read_step(0);
        read_step(1);
        search(31, 31, 0, 0);            // goal unreachable
        send(2'd3, 31, 31, 1, 31, 31, 31, 31, 1023);   // unused opcode
        load(0, 0, 1);
        load(1, 1, 1);
        search(0, 0, 1, 1);              // single diagonal step
        read_step(0);
        load(31, 31, 0);
        load(0, 0, 0);

        random_phase(33);

        // long receiver hold-off while commands keep coming: the core backs up
        hold_left <= 400;
        read_step(0);
        search(0, 0, 0, 0);
        load(5, 5, 0);
        read_step(1);
        // then stop sending until every result is back
        drain();

        send_idle = 82;
        recv_idle = 11;
        random_phase(33);
        drain();

        send_idle = 0;
        recv_idle = 0;
        random_phase(33);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/gas_pkg.sv
rtl/core/gas_cmd_if.sv
rtl/core/gas_rsp_if.sv
rtl/core/grid_astar_path_search.sv
test/gas_path_checker.sv
test/tb_grid_astar_path_search.sv
